[hdl/lidar_point_fov_filter_macros.svh]
// Assertion helpers for the lidar field-of-view filter.
// Every helper samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef LIDAR_POINT_FOV_FILTER_MACROS_SVH
`define LIDAR_POINT_FOV_FILTER_MACROS_SVH

// When ante holds, cons must hold at the same edge.
`define LPF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold.
`define LPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hdl/lpf_pkg.sv]
package lpf_pkg;

  localparam int COORD_BITS     = 20;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_BITS      = TRIG_FRAC_BITS + 1;
  localparam int RANGE_BITS     = 40;
  // Width of the point after the yaw turn and after the pitch turn.
  localparam int X1_W           = COORD_BITS + 2;
  localparam int X2_W           = COORD_BITS + 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = RANGE_BITS;
  // Cycles from an accepted start to the result strobe.
  localparam int PIPE_LAT       = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_YAW      = 3'd0,
    CFG_SIN_YAW      = 3'd1,
    CFG_COS_TILT     = 3'd2,
    CFG_SIN_TILT     = 3'd3,
    CFG_HEIGHT_LIMIT = 3'd4,
    CFG_MIN_RANGE_SQ = 3'd5,
    CFG_MAX_RANGE_SQ = 3'd6,
    CFG_COS_HALF_FOV = 3'd7
  } lpf_cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
  } lpf_in_t;

  typedef struct packed {
    logic                         keep;
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic signed [COORD_BITS-1:0] z_out;
  } lpf_out_t;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0]  cos_yaw;
    logic signed [TRIG_BITS-1:0]  sin_yaw;
    logic signed [TRIG_BITS-1:0]  cos_tilt;
    logic signed [TRIG_BITS-1:0]  sin_tilt;
    logic signed [COORD_BITS-1:0] height_limit;
    logic [RANGE_BITS-1:0]        min_range_sq;
    logic [RANGE_BITS-1:0]        max_range_sq;
    logic signed [TRIG_BITS-1:0]  cos_half_fov;
  } lpf_cfg_t;

  localparam lpf_cfg_t CFG_RESET = '{
    cos_yaw:      {1'b0, {(TRIG_BITS-1){1'b1}}},
    sin_yaw:      '0,
    cos_tilt:     {1'b0, {(TRIG_BITS-1){1'b1}}},
    sin_tilt:     '0,
    height_limit: {1'b0, {(COORD_BITS-1){1'b1}}},
    min_range_sq: '0,
    max_range_sq: {RANGE_BITS{1'b1}},
    cos_half_fov: {1'b1, {(TRIG_BITS-1){1'b0}}}
  };

endpackage

[hdl/lpf_cfg.sv]
module lpf_cfg import lpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output lpf_cfg_t              cfg_o
);

  lpf_cfg_t cfg_r;
  lpf_cfg_t cfg_nxt;
  logic     wr_en;

  // Writes never wait.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (lpf_cfg_idx_t'(cfg_index))
        CFG_COS_YAW:      cfg_nxt.cos_yaw      = cfg_data[TRIG_BITS-1:0];
        CFG_SIN_YAW:      cfg_nxt.sin_yaw      = cfg_data[TRIG_BITS-1:0];
        CFG_COS_TILT:     cfg_nxt.cos_tilt     = cfg_data[TRIG_BITS-1:0];
        CFG_SIN_TILT:     cfg_nxt.sin_tilt     = cfg_data[TRIG_BITS-1:0];
        CFG_HEIGHT_LIMIT: cfg_nxt.height_limit = cfg_data[COORD_BITS-1:0];
        CFG_MIN_RANGE_SQ: cfg_nxt.min_range_sq = cfg_data[RANGE_BITS-1:0];
        CFG_MAX_RANGE_SQ: cfg_nxt.max_range_sq = cfg_data[RANGE_BITS-1:0];
        CFG_COS_HALF_FOV: cfg_nxt.cos_half_fov = cfg_data[TRIG_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

[hdl/lpf_rot.sv]
module lpf_rot import lpf_pkg::*; #(
  parameter int A_W    = 20,
  parameter int SIDE_W = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [A_W-1:0]    b_i,
  input  logic signed [TRIG_BITS-1:0] c_i,
  input  logic signed [TRIG_BITS-1:0] s_i,
  input  logic signed [SIDE_W-1:0] side_i,
  output logic                     vld_o,
  output logic signed [A_W+1:0]    ra_o,
  output logic signed [A_W+1:0]    rb_o,
  output logic signed [SIDE_W-1:0] side_o
);

  localparam int P_W = A_W + TRIG_BITS;
  localparam int S_W = P_W + 1;
  localparam logic signed [S_W-1:0] RND_HALF = S_W'(1) <<< (TRIG_FRAC_BITS - 1);

  logic signed [P_W-1:0]    ac_r, bs_r, as_r, bc_r;
  logic signed [SIDE_W-1:0] side1_r, side2_r;
  logic                     vld1_r, vld2_r;
  logic signed [S_W-1:0]    sum_a, sum_b;
  logic signed [A_W+1:0]    ra_r, rb_r;

  // Stage one: the four products.
  always_ff @(posedge clk) begin
    ac_r    <= P_W'(a_i) * P_W'(c_i);
    bs_r    <= P_W'(b_i) * P_W'(s_i);
    as_r    <= P_W'(a_i) * P_W'(s_i);
    bc_r    <= P_W'(b_i) * P_W'(c_i);
    side1_r <= side_i;
  end

  // Stage two: exact sums, then round half up by dropping the fraction.
  assign sum_a = S_W'(ac_r) - S_W'(bs_r) + RND_HALF;
  assign sum_b = S_W'(as_r) + S_W'(bc_r) + RND_HALF;

  always_ff @(posedge clk) begin
    ra_r    <= sum_a[S_W-1:TRIG_FRAC_BITS];
    rb_r    <= sum_b[S_W-1:TRIG_FRAC_BITS];
    side2_r <= side1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  assign vld_o  = vld2_r;
  assign ra_o   = ra_r;
  assign rb_o   = rb_r;
  assign side_o = side2_r;

endmodule

[hdl/lpf_test.sv]
module lpf_test import lpf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_i,
  input  logic signed [X2_W-1:0]  x2_i,
  input  logic signed [X1_W-1:0]  y1_i,
  input  logic signed [X2_W-1:0]  z2_i,
  input  lpf_cfg_t                cfg_i,
  output logic                    vld_o,
  output lpf_out_t                res_o
);

  localparam int SQ_W  = 2 * X2_W;
  localparam int D_W   = SQ_W + 1;
  localparam int DL_W  = D_W / 2;
  localparam int DH_W  = D_W - DL_W;
  localparam int MC2_W = 2 * TRIG_BITS;
  localparam int CMP_W = (D_W > RANGE_BITS) ? D_W : RANGE_BITS;
  localparam int C_W   = MC2_W + D_W;

  typedef struct packed {
    logic                         xneg;
    logic                         hgt;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] sz;
  } carry_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [X2_W-1:0] v
  );
    logic ovf;
    ovf = (v[X2_W-1:COORD_BITS-1] != {(X2_W-COORD_BITS+1){v[X2_W-1]}});
    if (ovf) begin
      return v[X2_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return v[COORD_BITS-1:0];
  endfunction

  logic [X2_W-1:0]         mx, my;
  logic signed [X2_W-1:0]  y1x;
  logic [TRIG_BITS-1:0]    mc;
  logic                    v5_r, v6_r, v7_r, vld_r;
  logic [SQ_W-1:0]         sqx5_r, sqy5_r, sqx6_r, sqx7_r;
  carry_t                  c5_r, c6_r, c7_r;
  logic [D_W-1:0]          d2_r;
  logic [MC2_W-1:0]        mc2_r;
  logic                    cneg6_r, cneg7_r;
  logic [MC2_W+DL_W-1:0]   pl_r;
  logic [MC2_W+DH_W-1:0]   ph_r;
  logic                    rng_r;
  logic [C_W-1:0]          lhs, rhs;
  logic                    fov;
  lpf_out_t                res_r;

  // Stage five: magnitudes squared, height test, saturated outputs.
  assign y1x = X2_W'(y1_i);
  assign mx  = x2_i[X2_W-1] ? X2_W'(-x2_i) : X2_W'(x2_i);
  assign my  = y1x[X2_W-1]  ? X2_W'(-y1x)  : X2_W'(y1x);

  always_ff @(posedge clk) begin
    sqx5_r    <= SQ_W'(mx) * SQ_W'(mx);
    sqy5_r    <= SQ_W'(my) * SQ_W'(my);
    c5_r.xneg <= x2_i[X2_W-1];
    c5_r.hgt  <= z2_i < X2_W'(cfg_i.height_limit);
    c5_r.sx   <= sat_coord(x2_i);
    c5_r.sy   <= sat_coord(y1x);
    c5_r.sz   <= sat_coord(z2_i);
  end

  // Stage six: planar distance squared and the half-angle cosine squared.
  assign mc = cfg_i.cos_half_fov[TRIG_BITS-1] ? TRIG_BITS'(-cfg_i.cos_half_fov)
                                              : TRIG_BITS'(cfg_i.cos_half_fov);

  always_ff @(posedge clk) begin
    d2_r    <= D_W'(sqx5_r) + D_W'(sqy5_r);
    sqx6_r  <= sqx5_r;
    mc2_r   <= MC2_W'(mc) * MC2_W'(mc);
    cneg6_r <= cfg_i.cos_half_fov[TRIG_BITS-1];
    c6_r    <= c5_r;
  end

  // Stage seven: cos^2 times distance in two halves, range window.
  always_ff @(posedge clk) begin
    pl_r    <= (MC2_W+DL_W)'(mc2_r) * (MC2_W+DL_W)'(d2_r[DL_W-1:0]);
    ph_r    <= (MC2_W+DH_W)'(mc2_r) * (MC2_W+DH_W)'(d2_r[D_W-1:DL_W]);
    rng_r   <= (CMP_W'(d2_r) > CMP_W'(cfg_i.min_range_sq)) &&
               (CMP_W'(d2_r) <= CMP_W'(cfg_i.max_range_sq));
    sqx7_r  <= sqx6_r;
    cneg7_r <= cneg6_r;
    c7_r    <= c6_r;
  end

  // Stage eight: x^2 * 2^(2F) against c^2 * (x^2 + y^2), then the keep flag.
  assign lhs = C_W'(sqx7_r) << (2 * TRIG_FRAC_BITS);
  assign rhs = (C_W'(ph_r) << DL_W) + C_W'(pl_r);
  assign fov = cneg7_r ? (!c7_r.xneg || (lhs <= rhs)) : (!c7_r.xneg && (lhs >= rhs));

  always_ff @(posedge clk) begin
    res_r.keep  <= c7_r.hgt & rng_r & fov;
    res_r.x_out <= c7_r.sx;
    res_r.y_out <= c7_r.sy;
    res_r.z_out <= c7_r.sz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      v5_r  <= vld_i;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      vld_r <= v7_r;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule

[hdl/lidar_point_fov_filter.sv]
// Throughput: one point per cycle while busy is low, through the eight-stage multiply pipeline.
// Reset (rst_n low, synchronous): pipeline valid bits clear, config registers take their defaults,
// and busy is high so no point is taken; busy is low at all other times.
// The result side has no backpressure: each result shows for exactly one cycle.
`include "lidar_point_fov_filter_macros.svh"

module lidar_point_fov_filter import lpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lpf_in_t               in_point,
  output logic                  out_valid,
  output lpf_out_t              out_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The datapath is a straight pipeline:
  //   yaw turn about z       (products, then round-half-up sums)
  //   pitch turn about y     (same structure on the wider point)
  //   tests and saturation   (squares, distance, c^2 * distance, compare)
  // Every stage carries its own valid bit, so a point can enter on every clock while busy is low.

  lpf_cfg_t               cfg_q;
  logic                   accept;
  logic                   vld_s2, vld_s4;
  logic signed [X1_W-1:0] x1, y1;
  logic signed [COORD_BITS-1:0] z_s2;
  logic signed [X1_W-1:0] z_ext;
  logic signed [X2_W-1:0] x2, z2;
  logic signed [X1_W-1:0] y1_s4;

  // The only time the block refuses a point is during reset.
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Register file. Software must write it only while no point is in flight; the block does
  // not enforce this. Given that rule, every stage may read the live values without a per-point copy.
  lpf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg_q)
  );

  // Yaw: x1 = x*cy - y*sy, y1 = x*sy + y*cy. The height coordinate rides along.
  lpf_rot #(
    .A_W    (COORD_BITS),
    .SIDE_W (COORD_BITS)
  ) u_rot_yaw (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .a_i    (in_point.x_in),
    .b_i    (in_point.y_in),
    .c_i    (cfg_q.cos_yaw),
    .s_i    (cfg_q.sin_yaw),
    .side_i (in_point.z_in),
    .vld_o  (vld_s2),
    .ra_o   (x1),
    .rb_o   (y1),
    .side_o (z_s2)
  );

  // x1 is not saturated, so the pitch turn runs at the wider width and z is
  // sign-extended to match it.
  assign z_ext = X1_W'(z_s2);

  // Pitch: x2 = x1*ct - z*st, z2 = x1*st + z*ct. y1 rides along.
  lpf_rot #(
    .A_W    (X1_W),
    .SIDE_W (X1_W)
  ) u_rot_tilt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_s2),
    .a_i    (x1),
    .b_i    (z_ext),
    .c_i    (cfg_q.cos_tilt),
    .s_i    (cfg_q.sin_tilt),
    .side_i (y1),
    .vld_o  (vld_s4),
    .ra_o   (x2),
    .rb_o   (z2),
    .side_o (y1_s4)
  );

  // Height, range and field-of-view tests on the exact coordinates, and the
  // saturated copies that go out. The bearing test avoids atan2 by comparing
  // x^2 against cos^2 * (x^2 + y^2) with the sign of x deciding the direction.
  lpf_test u_test (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_s4),
    .x2_i  (x2),
    .y1_i  (y1_s4),
    .z2_i  (z2),
    .cfg_i (cfg_q),
    .vld_o (out_valid),
    .res_o (out_result)
  );

  // A result strobe always belongs to a point taken exactly one latency earlier.
  `LPF_ASSERT_IMPLIES(a_out_from_start, out_valid, $past(start && !busy, PIPE_LAT), "result without a matching start")

  // With a non-negative half-angle cosine only points ahead of the sensor are kept.
  `LPF_ASSERT_IMPLIES(a_keep_ahead, out_valid && out_result.keep && !$past(cfg_q.cos_half_fov[TRIG_BITS-1], 3), !out_result.x_out[COORD_BITS-1], "kept point behind sensor with narrow window")

  // A zero maximum range can never keep a point.
  `LPF_ASSERT_NEVER(a_keep_empty_range, out_valid && out_result.keep && ($past(cfg_q.max_range_sq, 2) == '0), "kept point with zero maximum range")

endmodule

[verif/tb_lidar_point_fov_filter.sv]
module tb_lidar_point_fov_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import lpf_pkg::*;

  // The run stops here even if the block hangs; this bound is far above the slowest correct run.
  localparam int RUN_LIMIT        = 200000;
  localparam int RANDOM_PHASES    = 14;
  localparam int POINTS_PER_PHASE = 125;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = COORD_BITS'(2 ** (COORD_BITS - 1) - 1);
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = COORD_BITS'(-(2 ** (COORD_BITS - 1)));
  localparam logic signed [TRIG_BITS-1:0]  TRIG_MAX  = TRIG_BITS'(2 ** (TRIG_BITS - 1) - 1);
  localparam logic signed [TRIG_BITS-1:0]  TRIG_MIN  = TRIG_BITS'(-(2 ** (TRIG_BITS - 1)));
  localparam real DEG_TO_RAD = 3.14159265358979 / 180.0;

  // The scoreboard keeps its own copy of the eight mounting and crop registers,
  // predicts the transformed point and keep flag for every accepted point, and
  // compares each result strobe against the oldest prediction still waiting.
  class fov_scoreboard;
    lpf_cfg_t settings;
    lpf_out_t predicted_points[$];
    int points_seen;
    int results_checked;
    int points_kept;
    int reg_writes;
    int mismatches;

    function new();
      settings = CFG_RESET;
    endfunction

    function int pending();
      return predicted_points.size();
    endfunction

    // Only the low bits that a register holds are kept; anything above is dropped.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_COS_YAW:      settings.cos_yaw      = data[TRIG_BITS-1:0];
        CFG_SIN_YAW:      settings.sin_yaw      = data[TRIG_BITS-1:0];
        CFG_COS_TILT:     settings.cos_tilt     = data[TRIG_BITS-1:0];
        CFG_SIN_TILT:     settings.sin_tilt     = data[TRIG_BITS-1:0];
        CFG_HEIGHT_LIMIT: settings.height_limit = data[COORD_BITS-1:0];
        CFG_MIN_RANGE_SQ: settings.min_range_sq = data[RANGE_BITS-1:0];
        CFG_MAX_RANGE_SQ: settings.max_range_sq = data[RANGE_BITS-1:0];
        CFG_COS_HALF_FOV: settings.cos_half_fov = data[TRIG_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Divide by 2^15 and round to nearest, halves upward: add half, then floor.
    function longint round_q15(longint v);
      return (v + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    endfunction

    function logic signed [COORD_BITS-1:0] clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return COORD_BITS'(hi);
      if (v < lo) return COORD_BITS'(lo);
      return COORD_BITS'(v);
    endfunction

    function lpf_out_t turn_and_crop(lpf_in_t p);
      longint x, y, z, cy, sy, ct, st, chf, hl;
      longint x1, y1, x2, z2;
      longint unsigned mx, my, mc, d2;
      logic [127:0] lhs, rhs, a, b;
      bit in_height, in_range, in_fov;
      lpf_out_t r;
      x   = longint'(p.x_in);
      y   = longint'(p.y_in);
      z   = longint'(p.z_in);
      cy  = longint'(settings.cos_yaw);
      sy  = longint'(settings.sin_yaw);
      ct  = longint'(settings.cos_tilt);
      st  = longint'(settings.sin_tilt);
      chf = longint'(settings.cos_half_fov);
      hl  = longint'(settings.height_limit);
      // Yaw about z first, then pitch about y. Neither intermediate is clamped.
      x1 = round_q15(x * cy - y * sy);
      y1 = round_q15(x * sy + y * cy);
      x2 = round_q15(x1 * ct - z * st);
      z2 = round_q15(x1 * st + z * ct);
      mx = (x2 < 0) ? -x2 : x2;
      my = (y1 < 0) ? -y1 : y1;
      mc = (chf < 0) ? -chf : chf;
      // At these widths the planar distance squared stays well inside 64 bits.
      d2 = mx * mx + my * my;
      in_height = z2 < hl;
      in_range  = (d2 > settings.min_range_sq) && (d2 <= settings.max_range_sq);
      if (mx == 0 && my == 0) begin
        // A point on the axis has zero bearing and is always inside the window.
        in_fov = 1'b1;
      end else begin
        // cos(bearing) >= c, squared: (x * 2^15)^2 against c^2 * (x^2 + y^2).
        a   = 128'(mx) << TRIG_FRAC_BITS;
        lhs = a * a;
        a   = 128'(mc) * 128'(mx);
        b   = 128'(mc) * 128'(my);
        rhs = a * a + b * b;
        if (chf >= 0) in_fov = (x2 >= 0) && (lhs >= rhs);
        else          in_fov = (x2 >= 0) || (lhs <= rhs);
      end
      r.keep  = in_height && in_range && in_fov;
      r.x_out = clamp_coord(x2);
      r.y_out = clamp_coord(y1);
      r.z_out = clamp_coord(z2);
      return r;
    endfunction

    function void note_point(lpf_in_t p);
      predicted_points.push_back(turn_and_crop(p));
      points_seen++;
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(lpf_out_t got);
      lpf_out_t want;
      if (predicted_points.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no point outstanding, expected none, got %0b %0d %0d %0d",
                 $time, got.keep, got.x_out, got.y_out, got.z_out);
        return;
      end
      want = predicted_points.pop_front();
      results_checked++;
      if (want.keep) points_kept++;
      check_field("keep", 32'(want.keep), 32'(got.keep));
      check_field("x_out", 32'(want.x_out), 32'(got.x_out));
      check_field("y_out", 32'(want.y_out), 32'(got.y_out));
      check_field("z_out", 32'(want.z_out), 32'(got.z_out));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  lpf_in_t               in_point  = '0;
  logic                  out_valid;
  lpf_out_t              out_result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  fov_scoreboard sb = new();
  int cycle_count = 0;
  int settings_used = 1;

  lidar_point_fov_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point   (in_point),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // All three channels are observed at the rising edge, where the values seen
  // are the ones that the edge itself samples. A register write transfer
  // updates the scoreboard's copy, a start transfer queues a prediction, and a
  // result strobe is checked at once, since the block cannot be held off.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_point(in_point);
      if (out_valid) sb.check_result(out_result);
    end
  end

  // Watchdog against a hung pipeline or a channel that never completes a transfer.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic lpf_in_t make_point(int x, int y, int z);
    lpf_in_t p;
    p.x_in = COORD_BITS'(x);
    p.y_in = COORD_BITS'(y);
    p.z_in = COORD_BITS'(z);
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_wide(int n);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (n < CFG_DATA_W) v = v & ((64'd1 << n) - 64'd1);
    return v[CFG_DATA_W-1:0];
  endfunction

  // Coordinates are drawn at a random bit length so that short and long
  // ranges both show up, with the axis extremes mixed in now and then.
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int w;
    int v;
    case ($urandom_range(0, 19))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return '1;
      default: begin
        w = $urandom_range(1, COORD_BITS);
        v = $signed($urandom) >>> (32 - w);
        return v[COORD_BITS-1:0];
      end
    endcase
  endfunction

  function automatic logic signed [TRIG_BITS-1:0] q15_of(real v);
    return TRIG_BITS'($rtoi(v * 32767.0));
  endfunction

  // Holds start high until the block takes the point. start is left high on
  // return so that back-to-back transfers need no extra assignment.
  task automatic offer_point(lpf_in_t p, bit gaps);
    while (gaps && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result has been seen. The
  // first edge lets the monitor record a transfer that happened on the
  // edge where the last offer returned.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One register write transfer. Half the time the bits above the register's
  // width carry noise, which the block has to drop. cfg_valid stays high on
  // return; the caller lowers it once the batch is done.
  task automatic set_reg(lpf_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value, int w);
    logic [CFG_DATA_W-1:0] reg_mask;
    logic [CFG_DATA_W-1:0] noise;
    reg_mask = (CFG_DATA_W'(1) << w) - 1'b1;
    noise = $urandom_range(0, 1) ? rand_wide(CFG_DATA_W) : '0;
    if ($urandom_range(0, 99) < 31) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_index <= idx;
    cfg_data  <= (value & reg_mask) | (noise & ~reg_mask);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(logic signed [TRIG_BITS-1:0] cy, logic signed [TRIG_BITS-1:0] sy,
                                logic signed [TRIG_BITS-1:0] ct, logic signed [TRIG_BITS-1:0] st,
                                logic signed [COORD_BITS-1:0] hl, logic [RANGE_BITS-1:0] lo,
                                logic [RANGE_BITS-1:0] hi, logic signed [TRIG_BITS-1:0] chf);
    set_reg(CFG_COS_YAW, CFG_DATA_W'(cy), TRIG_BITS);
    set_reg(CFG_SIN_YAW, CFG_DATA_W'(sy), TRIG_BITS);
    set_reg(CFG_COS_TILT, CFG_DATA_W'(ct), TRIG_BITS);
    set_reg(CFG_SIN_TILT, CFG_DATA_W'(st), TRIG_BITS);
    set_reg(CFG_HEIGHT_LIMIT, CFG_DATA_W'(hl), COORD_BITS);
    set_reg(CFG_MIN_RANGE_SQ, lo, RANGE_BITS);
    set_reg(CFG_MAX_RANGE_SQ, hi, RANGE_BITS);
    set_reg(CFG_COS_HALF_FOV, CFG_DATA_W'(chf), TRIG_BITS);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Chooses the register settings for one random phase. The first two phases
  // pin every register to an end of its range; the rest mix real mounting
  // angles, raw trig words off the unit circle and a straight-ahead mount.
  task automatic program_phase(int k);
    real yaw, pitch, half;
    logic signed [TRIG_BITS-1:0] cy, sy, ct, st, chf;
    logic signed [COORD_BITS-1:0] hl;
    logic [RANGE_BITS-1:0] lo, hi;
    yaw   = $urandom_range(0, 3599) * 0.1;
    pitch = $urandom_range(0, 3599) * 0.1;
    half  = $urandom_range(0, 1800) * 0.1;
    cy  = q15_of($cos(yaw * DEG_TO_RAD));
    sy  = q15_of($sin(yaw * DEG_TO_RAD));
    ct  = q15_of($cos(pitch * DEG_TO_RAD));
    st  = q15_of($sin(pitch * DEG_TO_RAD));
    chf = q15_of($cos(half * DEG_TO_RAD));
    hl  = rand_coord();
    // Range bounds at random scales, so that both sides of each bound are hit.
    lo = rand_wide($urandom_range(0, 38));
    hi = lo + rand_wide($urandom_range(0, RANGE_BITS));
    if (hi < lo) hi = '1;
    case ($urandom_range(0, 7))
      0: lo = '0;
      1: hi = '1;
      2: lo = '1;
      default: ;
    endcase
    case ((k < 2) ? k : $urandom_range(2, 5))
      0: begin
        cy = TRIG_MIN; sy = TRIG_MIN; ct = TRIG_MIN; st = TRIG_MIN;
        hl = COORD_MAX; lo = '0; hi = '1; chf = TRIG_MIN;
      end
      1: begin
        cy = TRIG_MAX; sy = TRIG_MAX; ct = TRIG_MAX; st = TRIG_MAX;
        hl = COORD_MIN; lo = '0; hi = '0; chf = TRIG_MAX;
      end
      2: begin
        cy = TRIG_BITS'($urandom); sy = TRIG_BITS'($urandom);
        ct = TRIG_BITS'($urandom); st = TRIG_BITS'($urandom);
      end
      3: begin
        cy = TRIG_MAX; sy = '0; ct = TRIG_MAX; st = '0;
      end
      default: ;
    endcase
    apply_settings(cy, sy, ct, st, hl, lo, hi, chf);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the origin, every axis extreme and a few small points.
    offer_point(make_point(0, 0, 0), 1'b1);
    offer_point(make_point(int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX)), 1'b1);
    offer_point(make_point(int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN)), 1'b1);
    offer_point(make_point(int'(COORD_MAX), 0, 0), 1'b1);
    offer_point(make_point(int'(COORD_MIN), 0, 0), 1'b1);
    offer_point(make_point(0, int'(COORD_MAX), 0), 1'b1);
    offer_point(make_point(0, int'(COORD_MIN), 0), 1'b1);
    offer_point(make_point(0, 0, int'(COORD_MAX)), 1'b1);
    offer_point(make_point(0, 0, int'(COORD_MIN)), 1'b1);
    offer_point(make_point(1, -1, 0), 1'b1);
    offer_point(make_point(-1, 1, -1), 1'b1);
    offer_point(make_point(int'(COORD_MAX), int'(COORD_MIN), 0), 1'b1);
    offer_point(make_point(12345, -6789, -100), 1'b1);

    // Straight-ahead mount with a 90 degree half angle: points on the y axis
    // sit exactly on the window edge and must be kept.
    drain();
    apply_settings(TRIG_MAX, '0, TRIG_MAX, '0, '0, '0, '1, '0);
    offer_point(make_point(0, 700, -5), 1'b1);
    offer_point(make_point(0, -700, -5), 1'b1);
    offer_point(make_point(-1, 700, -5), 1'b1);
    offer_point(make_point(0, 0, 10), 1'b1);

    // Half-angle cosine of -1: the window covers every bearing, including the
    // edge case straight behind the sensor.
    drain();
    set_reg(CFG_COS_HALF_FOV, CFG_DATA_W'(TRIG_MIN), TRIG_BITS);
    cfg_valid <= 1'b0;
    offer_point(make_point(-1000, 0, -1), 1'b1);
    offer_point(make_point(-1000, 1, -1), 1'b1);
    offer_point(make_point(int'(COORD_MIN), 0, int'(COORD_MIN)), 1'b1);

    // Random phases. Phase 2 sends without any gaps; phase 4 stops halfway and
    // lets the pipeline run dry before carrying on.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain();
      program_phase(k);
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        if (k == 4 && i == POINTS_PER_PHASE / 2) drain();
        offer_point(make_point(int'(rand_coord()), int'(rand_coord()), int'(rand_coord())),
                    k != 2);
      end
    end

    drain();
    // Wait on so that any stray result strobe would be caught.
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("Sent %0d points under %0d register settings (%0d register writes).",
             sb.points_seen, settings_used, sb.reg_writes);
    $display("Checked %0d results, %0d kept; %0d field mismatches, %0d left outstanding.",
             sb.results_checked, sb.points_kept, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
